### rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctl_type;

endpackage

`default_nettype wire

### rtl/stable_priority_queue_top.sv
// Channel   Handshake          Ports
// request   start & !busy      req_type, req_in_data, req_in_priority
// response  rsp_valid strobe   rsp_status, rsp_popped_*, rsp_head_*, rsp_entry_count
//
// Each accepted word is handled by a row of DEPTH cells that shift left or
// right in parallel; its response is registered and appears in the cycle after.
// busy is held low, so a new word may be started every cycle.
// Reset empties the queue; stored payload is not cleared.
// The response cannot be stalled and is shown for exactly one cycle.
`default_nettype none

module stable_priority_queue_top
   import spq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_type,
   input  wire logic signed [DATA_WIDTH-1:0] req_in_data,
   input  wire logic [PRIO_WIDTH-1:0]        req_in_priority,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [DATA_WIDTH-1:0]      rsp_popped_data,
   output logic [PRIO_WIDTH-1:0]             rsp_popped_priority,
   output logic                              rsp_head_valid,
   output logic signed [DATA_WIDTH-1:0]      rsp_head_data,
   output logic [PRIO_WIDTH-1:0]             rsp_head_priority,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      cell_after;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];

   cell_ctl_type ctl;
   logic         accept;
   logic         full;
   logic         empty;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   status_type            status_ff;
   status_type            status_in;
   logic [DATA_WIDTH-1:0] pop_data_ff;
   logic [DATA_WIDTH-1:0] pop_data_in;
   logic [PRIO_WIDTH-1:0] pop_prio_ff;
   logic [PRIO_WIDTH-1:0] pop_prio_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = cell_valid[DEPTH-1];
   assign empty  = !cell_valid[0];

   always_comb begin
      ctl          = '0;
      rsp_valid_in = accept;
      status_in    = STATUS_OK;
      pop_data_in  = '0;
      pop_prio_in  = '0;
      count_in     = count_ff;
      if (accept) begin
         if (req_type == REQ_PUSH) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ctl.push = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ctl.pop     = 1'b1;
               pop_data_in = cell_data[0];
               pop_prio_in = cell_prio[0];
               count_in    = count_ff - 1'b1;
            end
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                  l_valid;
      logic [DATA_WIDTH-1:0] l_data;
      logic [PRIO_WIDTH-1:0] l_prio;
      logic                  l_after;
      logic                  r_valid;
      logic [DATA_WIDTH-1:0] r_data;
      logic [PRIO_WIDTH-1:0] r_prio;

      if (i == 0) begin : g_first
         assign l_valid = 1'b0;
         assign l_data  = '0;
         assign l_prio  = '0;
         assign l_after = 1'b1;
      end else begin : g_mid
         assign l_valid = cell_valid[i-1];
         assign l_data  = cell_data[i-1];
         assign l_prio  = cell_prio[i-1];
         assign l_after = cell_after[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign r_valid = 1'b0;
         assign r_data  = '0;
         assign r_prio  = '0;
      end else begin : g_inner
         assign r_valid = cell_valid[i+1];
         assign r_data  = cell_data[i+1];
         assign r_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .PRIO_WIDTH(PRIO_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .new_data      (req_in_data),
         .new_priority  (req_in_priority),
         .left_valid    (l_valid),
         .left_data     (l_data),
         .left_priority (l_prio),
         .left_after    (l_after),
         .right_valid   (r_valid),
         .right_data    (r_data),
         .right_priority(r_prio),
         .valid         (cell_valid[i]),
         .data          (cell_data[i]),
         .priority_value(cell_prio[i]),
         .after         (cell_after[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      pop_data_ff <= pop_data_in;
      pop_prio_ff <= pop_prio_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_popped_data     = pop_data_ff;
   assign rsp_popped_priority = pop_prio_ff;
   assign rsp_head_valid      = cell_valid[0];
   assign rsp_head_data       = cell_valid[0] ? cell_data[0] : '0;
   assign rsp_head_priority   = cell_valid[0] ? cell_prio[0] : '0;
   assign rsp_entry_count     = count_ff;

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(cell_valid)))
      else $error("entry count differs from occupied cells");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid >> 1) & ~cell_valid) == '0)
      else $error("occupied cells are not packed toward the head");

   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept))
      else $error("response without an accepted word");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_FULL) |-> count_ff == CNT_W'(DEPTH))
      else $error("full status while queue not full");

endmodule

`default_nettype wire

### rtl/spq_cell.sv
`default_nettype none

module spq_cell
   import spq_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_ctl_type          ctl,
   input  wire logic [DATA_WIDTH-1:0] new_data,
   input  wire logic [PRIO_WIDTH-1:0] new_priority,
   input  wire logic                  left_valid,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic [PRIO_WIDTH-1:0] left_priority,
   input  wire logic                  left_after,
   input  wire logic                  right_valid,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   input  wire logic [PRIO_WIDTH-1:0] right_priority,
   output logic                       valid,
   output logic [DATA_WIDTH-1:0]      data,
   output logic [PRIO_WIDTH-1:0]      priority_value,
   output logic                       after
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic [PRIO_WIDTH-1:0] prio_ff;
   logic [PRIO_WIDTH-1:0] prio_in;

   // The new word sorts behind this cell when the cell holds an equal or smaller priority.
   assign after = valid_ff && (prio_ff <= new_priority);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      if (ctl.push && !after) begin
         if (left_after) begin
            valid_in = 1'b1;
            data_in  = new_data;
            prio_in  = new_priority;
         end else begin
            valid_in = left_valid;
            data_in  = left_data;
            prio_in  = left_priority;
         end
      end else if (ctl.pop) begin
         valid_in = right_valid;
         data_in  = right_data;
         prio_in  = right_priority;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign valid          = valid_ff;
   assign data           = data_ff;
   assign priority_value = prio_ff;

endmodule

`default_nettype wire
